// ----- rtl/a51kc_pkg.sv -----
// ----------------------------------------------------------------------------
// a51kc_pkg
// Shared types and constants for the A5/1 keystream cipher unit: register
// lengths, step counts of each phase and the step command of the shift core.
// ----------------------------------------------------------------------------
`default_nettype none

package a51kc_pkg;

   // Lengths of the three shift registers.
   localparam int LEN_ONE   = 19;
   localparam int LEN_TWO   = 22;
   localparam int LEN_THREE = 23;

   // Field widths of the configuration registers and the data word.
   localparam int KEY_BITS   = 64;
   localparam int FRAME_BITS = 22;
   localparam int MSG_BITS   = 64;

   // Step counts of the phases.
   localparam int MIX_STEPS = 100;
   localparam int KS_STEPS  = 228;
   localparam int HALF      = 114;
   localparam int HIGH_BITS = HALF - MSG_BITS;

   // Step counter, wide enough for the longest phase.
   localparam int CNT_W = $clog2(KS_STEPS);

   // Command to the shift core for one cycle.
   typedef struct packed {
      logic clear;     // zero all three registers
      logic load;      // clock all three with the load bit folded in
      logic load_bit;  // key or frame bit for a load step
      logic maj;       // majority-clocked step
   } core_ctrl_type;

endpackage : a51kc_pkg

`default_nettype wire

// ----- rtl/a5_1_keystream_cipher_unit.sv -----
// ----------------------------------------------------------------------------
// a5_1_keystream_cipher_unit
// A5/1 stream cipher: one 64-bit data word in, one 114-bit XOR result out.
// ----------------------------------------------------------------------------
// Usage:
// The user must write the session key (address 0) and frame number
// (address 8) over the APB port only while the unit is idle; the unit itself
// does not enforce this. Reads return the stored values. A word enters on
// the req_ channel (op, message) when req_valid and req_ready are both high.
// The unit clears its three shift registers, clocks in 64 key and 22 frame
// bits, runs 100 mixing steps and then 114 (encrypt) or 228 (decrypt)
// keystream steps, one register clock per cycle through a single shared
// shift core, and then forms the result in the output register for the
// rsp_ channel. req_ready is high only while no word is in work, so a new
// word is taken only once the last has gone to the output register.
// A finished result sits in the output register until rsp_ready takes it;
// the next word may be accepted meanwhile, and if its own result is done
// before the first is taken, the unit holds it until the output is free.
// Reset clears both configuration registers and the control state.
// ----------------------------------------------------------------------------
`default_nettype none

module a5_1_keystream_cipher_unit
   import a51kc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // Input words
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_op,
   input  wire logic [MSG_BITS-1:0]  req_message,
   // Result words
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [MSG_BITS-1:0]       rsp_result_low,
   output logic [HIGH_BITS-1:0]      rsp_result_high,
   // Configuration
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [3:0]           paddr,
   input  wire logic [63:0]          pwdata,
   output logic [63:0]               prdata,
   output logic                      pready
);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_KEY   = 3'd1;
   localparam logic [2:0] ST_FRAME = 3'd2;
   localparam logic [2:0] ST_MIX   = 3'd3;
   localparam logic [2:0] ST_KS    = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   // Register indexes on the configuration port.
   localparam logic REG_KEY   = 1'b0;
   localparam logic REG_FRAME = 1'b1;

   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic [2:0]            state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  op_ff, op_in;
   logic [MSG_BITS-1:0]   msg_ff, msg_in;
   logic [HALF-1:0]       ks_ff, ks_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MSG_BITS-1:0]   low_ff, low_in;
   logic [HIGH_BITS-1:0]  high_ff, high_in;
   logic                  cfg_write;
   logic                  req_accept;
   logic                  out_free;
   logic                  count_zero;
   logic                  ks_bit;
   core_ctrl_type         ctrl;

   // Configuration port: always ready, writes in the access cycle.
   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite & pready;

   always_comb begin
      key_in   = key_ff;
      frame_in = frame_ff;
      if (cfg_write) begin
         unique case (paddr[3])
            REG_KEY:   key_in   = pwdata;
            REG_FRAME: frame_in = pwdata[FRAME_BITS-1:0];
            default:   ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3])
         REG_KEY:   prdata = key_ff;
         REG_FRAME: prdata = {{(64-FRAME_BITS){1'b0}}, frame_ff};
         default:   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '0;
         frame_ff <= '0;
      end else begin
         key_ff   <= key_in;
         frame_ff <= frame_in;
      end
   end

   // Handshake helpers.
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid & req_ready;
   assign out_free   = ~rsp_valid_ff | rsp_ready;
   assign count_zero = (count_ff == '0);

   // Sequencer: one shift-core command per cycle.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      msg_in       = msg_ff;
      ks_in        = ks_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      ctrl         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in      = req_op;
               msg_in     = req_message;
               ctrl.clear = 1'b1;
               count_in   = CNT_W'(KEY_BITS - 1);
               state_in   = ST_KEY;
            end
         end
         ST_KEY: begin
            ctrl.load     = 1'b1;
            ctrl.load_bit = key_ff[count_ff[$clog2(KEY_BITS)-1:0]];
            if (count_zero) begin
               count_in = CNT_W'(FRAME_BITS - 1);
               state_in = ST_FRAME;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         ST_FRAME: begin
            ctrl.load     = 1'b1;
            ctrl.load_bit = frame_ff[count_ff[$clog2(FRAME_BITS)-1:0]];
            if (count_zero) begin
               count_in = CNT_W'(MIX_STEPS - 1);
               state_in = ST_MIX;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         ST_MIX: begin
            ctrl.maj = 1'b1;
            if (count_zero) begin
               // Decrypt keeps the last half, so it runs the full stream.
               count_in = op_ff ? CNT_W'(KS_STEPS - 1) : CNT_W'(HALF - 1);
               state_in = ST_KS;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         ST_KS: begin
            // The first bit of the kept half lands in the top result bit.
            ctrl.maj = 1'b1;
            ks_in    = {ks_ff[HALF-2:0], ks_bit};
            if (count_zero) begin
               state_in = ST_DONE;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               low_in       = msg_ff ^ ks_ff[MSG_BITS-1:0];
               high_in      = ks_ff[HALF-1:MSG_BITS];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      op_ff    <= op_in;
      msg_ff   <= msg_in;
      ks_ff    <= ks_in;
      low_ff   <= low_in;
      high_ff  <= high_in;
   end

   // Shared shift core.
   a51kc_lfsr_core u_core (
      .clock  (clock),
      .ctrl   (ctrl),
      .ks_bit (ks_bit)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_low  = low_ff;
   assign rsp_result_high = high_ff;

endmodule : a5_1_keystream_cipher_unit

`default_nettype wire

// ----- rtl/a51kc_lfsr_core.sv -----
// ----------------------------------------------------------------------------
// a51kc_lfsr_core
// The three A5/1 shift registers with their shared step logic. One command
// per cycle: clear, load step or majority-clocked step. The keystream bit is
// taken from the register tops after the step.
// ----------------------------------------------------------------------------
`default_nettype none

module a51kc_lfsr_core
   import a51kc_pkg::*;
(
   input  wire logic          clock,
   input  wire core_ctrl_type ctrl,
   output logic               ks_bit
);

   logic [LEN_ONE-1:0]   r1_ff, r1_in;
   logic [LEN_TWO-1:0]   r2_ff, r2_in;
   logic [LEN_THREE-1:0] r3_ff, r3_in;
   logic                 fb1, fb2, fb3;
   logic                 c1, c2, c3, maj_val;

   // Feedback taps of each register.
   assign fb1 = r1_ff[18] ^ r1_ff[17] ^ r1_ff[16] ^ r1_ff[13];
   assign fb2 = r2_ff[21] ^ r2_ff[20];
   assign fb3 = r3_ff[22] ^ r3_ff[21] ^ r3_ff[20] ^ r3_ff[7];

   // Clocking bits and their majority.
   assign c1      = r1_ff[8];
   assign c2      = r2_ff[10];
   assign c3      = r3_ff[10];
   assign maj_val = (c1 & c2) | (c1 & c3) | (c2 & c3);

   // Next register values for the commanded step.
   always_comb begin
      r1_in = r1_ff;
      r2_in = r2_ff;
      r3_in = r3_ff;
      if (ctrl.clear) begin
         r1_in = '0;
         r2_in = '0;
         r3_in = '0;
      end else if (ctrl.load) begin
         r1_in = {r1_ff[LEN_ONE-2:0],   fb1 ^ ctrl.load_bit};
         r2_in = {r2_ff[LEN_TWO-2:0],   fb2 ^ ctrl.load_bit};
         r3_in = {r3_ff[LEN_THREE-2:0], fb3 ^ ctrl.load_bit};
      end else if (ctrl.maj) begin
         if (c1 == maj_val) r1_in = {r1_ff[LEN_ONE-2:0],   fb1};
         if (c2 == maj_val) r2_in = {r2_ff[LEN_TWO-2:0],   fb2};
         if (c3 == maj_val) r3_in = {r3_ff[LEN_THREE-2:0], fb3};
      end
   end

   // The registers are always set by a clear before use.
   always_ff @(posedge clock) begin
      r1_ff <= r1_in;
      r2_ff <= r2_in;
      r3_ff <= r3_in;
   end

   // Keystream bit from the tops after this step.
   assign ks_bit = r1_in[LEN_ONE-1] ^ r2_in[LEN_TWO-1] ^ r3_in[LEN_THREE-1];

endmodule : a51kc_lfsr_core

`default_nettype wire

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// A5/1 keystream cipher unit testbench
// Sends data words over the req_ channel under a range of session keys and
// frame numbers. Each accepted word is run through a local bit-level model
// of the three majority-clocked shift registers, and each result word on the
// rsp_ channel is checked against the oldest prediction. Both sides idle in
// random bursts, and one long receiver hold-off fills the unit.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
   import a51kc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Operation codes and register addresses (64-bit registers, 8-byte stride).
   localparam logic       OP_ENCRYPT = 1'b0;
   localparam logic       OP_DECRYPT = 1'b1;
   localparam logic [3:0] ADDR_KEY   = 4'd0;
   localparam logic [3:0] ADDR_FRAME = 4'd8;

   // Cycles without any handshake before the run is declared hung.
   localparam int STALL_LIMIT   = 6000;
   // Cycles the receiver holds off during the back-pressure test.
   localparam int LONG_HOLD     = 1500;
   // Settle time once nothing is expected; covers the longest word latency.
   localparam int SETTLE_CYCLES = 450;

   typedef struct {
      logic [MSG_BITS-1:0]  low;
      logic [HIGH_BITS-1:0] high;
   } cipher_word_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_op;
   logic [MSG_BITS-1:0]  req_message;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [MSG_BITS-1:0]  rsp_result_low;
   logic [HIGH_BITS-1:0] rsp_result_high;
   logic                 psel;
   logic                 penable;
   logic                 pwrite;
   logic [3:0]           paddr;
   logic [63:0]          pwdata;
   logic [63:0]          prdata;
   logic                 pready;

   // Local copy of the configuration and the words still owed by the unit.
   logic [KEY_BITS-1:0]   key_cfg;
   logic [FRAME_BITS-1:0] frame_cfg;
   cipher_word_type       expected_words[$];
   int                    mismatch_count;
   bit                    idle_on;
   int                    hold_left;
   int                    idle_cycles;

   a5_1_keystream_cipher_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_message     (req_message),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_low  (rsp_result_low),
      .rsp_result_high (rsp_result_high),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Bit-level cipher: load key and frame, mix, run out the keystream and
   // XOR the selected half into the zero-extended message.
   function automatic cipher_word_type predict_cipher(input logic op,
                                                      input logic [MSG_BITS-1:0] msg,
                                                      input logic [KEY_BITS-1:0] key,
                                                      input logic [FRAME_BITS-1:0] frame);
      logic [LEN_ONE-1:0]               r1;
      logic [LEN_TWO-1:0]               r2;
      logic [LEN_THREE-1:0]             r3;
      logic [KEY_BITS+FRAME_BITS-1:0]   seed;
      logic [KS_STEPS-1:0]              stream;
      logic [HALF-1:0]                  pad;
      logic [HALF-1:0]                  sum;
      logic                             b;
      logic                             c1;
      logic                             c2;
      logic                             c3;
      logic                             maj;
      int                               i;
      int                               s;
      cipher_word_type                  word;
      r1   = '0;
      r2   = '0;
      r3   = '0;
      seed = {key, frame};
      // Key bits then frame bits, most significant first, into every register.
      for (i = KEY_BITS + FRAME_BITS - 1; i >= 0; i--) begin
         b  = seed[i];
         r1 = {r1[LEN_ONE-2:0], r1[18] ^ r1[17] ^ r1[16] ^ r1[13] ^ b};
         r2 = {r2[LEN_TWO-2:0], r2[21] ^ r2[20] ^ b};
         r3 = {r3[LEN_THREE-2:0], r3[22] ^ r3[21] ^ r3[20] ^ r3[7] ^ b};
      end
      // Majority clocking; keystream bits are taken after the mixing steps.
      for (s = 0; s < MIX_STEPS + KS_STEPS; s++) begin
         c1  = r1[8];
         c2  = r2[10];
         c3  = r3[10];
         maj = (c1 & c2) | (c1 & c3) | (c2 & c3);
         if (c1 == maj) begin
            r1 = {r1[LEN_ONE-2:0], r1[18] ^ r1[17] ^ r1[16] ^ r1[13]};
         end
         if (c2 == maj) begin
            r2 = {r2[LEN_TWO-2:0], r2[21] ^ r2[20]};
         end
         if (c3 == maj) begin
            r3 = {r3[LEN_THREE-2:0], r3[22] ^ r3[21] ^ r3[20] ^ r3[7]};
         end
         if (s >= MIX_STEPS) begin
            stream[s-MIX_STEPS] = r1[18] ^ r2[21] ^ r3[22];
         end
      end
      // Result bit i pairs with keystream bit 113-i (encrypt) or 227-i (decrypt).
      for (i = 0; i < HALF; i++) begin
         pad[i] = (op == OP_DECRYPT) ? stream[KS_STEPS-1-i] : stream[HALF-1-i];
      end
      sum       = {{HIGH_BITS{1'b0}}, msg} ^ pad;
      word.low  = sum[MSG_BITS-1:0];
      word.high = sum[HALF-1:MSG_BITS];
      return word;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
   endtask

   // Random message with a bias toward edge patterns.
   function automatic logic [MSG_BITS-1:0] pick_message();
      logic [MSG_BITS-1:0] m;
      case ($urandom_range(0, 9))
         0: m = '0;
         1: m = '1;
         2: m = 64'd1 << $urandom_range(0, MSG_BITS - 1);
         3: m = ~(64'd1 << $urandom_range(0, MSG_BITS - 1));
         default: m = {$urandom, $urandom};
      endcase
      return m;
   endfunction

   // Offer one word and hold it until accepted; called and left at a falling edge.
   task automatic send_word(input logic op, input logic [MSG_BITS-1:0] msg);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_op      <= op;
      req_message <= msg;
      do @(posedge clock); while (!req_ready);
      expected_words.push_back(predict_cipher(op, msg, key_cfg, frame_cfg));
      @(negedge clock);
   endtask

   // Stop offering and wait until every owed word has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) begin
         @(negedge clock);
      end
      @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   task automatic write_csr(input logic [3:0] addr, input logic [63:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == ADDR_KEY) begin
         key_cfg = data;
      end else if (addr == ADDR_FRAME) begin
         frame_cfg = data[FRAME_BITS-1:0];
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // New key and frame, written only once the unit is idle.
   task automatic set_config(input logic [KEY_BITS-1:0] key, input logic [63:0] frame_word);
      drain();
      write_csr(ADDR_KEY, key);
      write_csr(ADDR_FRAME, frame_word);
   endtask

   // Directed words: all-zero registers pass data through, then extreme settings.
   task automatic test_directed();
      send_word(OP_ENCRYPT, '0);
      send_word(OP_ENCRYPT, '1);
      send_word(OP_DECRYPT, '1);
      send_word(OP_DECRYPT, 64'h8000_0000_0000_0001);
      // Frame write with bits above the field set; those must be dropped.
      set_config('1, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(OP_ENCRYPT, '0);
      send_word(OP_DECRYPT, '0);
      send_word(OP_ENCRYPT, '1);
      send_word(OP_DECRYPT, '1);
      send_word(OP_ENCRYPT, 64'hAAAA_AAAA_AAAA_AAAA);
      send_word(OP_DECRYPT, 64'h5555_5555_5555_5555);
      set_config('0, 64'h3F_FFFF);
      send_word(OP_ENCRYPT, 64'h1);
      send_word(OP_DECRYPT, 64'h8000_0000_0000_0000);
      set_config('1, 64'h0);
      send_word(OP_ENCRYPT, 64'h0123_4567_89AB_CDEF);
      send_word(OP_DECRYPT, 64'hFEDC_BA98_7654_3210);
      set_config(64'h1, 64'h1);
      send_word(OP_ENCRYPT, '1);
      send_word(OP_DECRYPT, '0);
      set_config(64'h8000_0000_0000_0000, 64'h20_0000);
      send_word(OP_ENCRYPT, '0);
      send_word(OP_DECRYPT, '1);
   endtask

   // Random words over a series of random and extreme settings.
   task automatic test_random_settings();
      int            phase;
      int            n;
      logic [63:0]   key;
      logic [63:0]   frame_word;
      for (phase = 0; phase < 8; phase++) begin
         key        = {$urandom, $urandom};
         frame_word = {$urandom, $urandom};
         if (phase == 0) begin
            key = '1;
         end else if (phase == 1) begin
            frame_word = 64'h3F_FFFF;
            key        = '0;
         end else if (phase == 2) begin
            frame_word = '0;
         end
         set_config(key, frame_word);
         for (n = 0; n < 120; n++) begin
            send_word(logic'($urandom_range(0, 1)), pick_message());
         end
      end
   endtask

   // Receiver holds off long enough for the unit to fill and stall its input.
   task automatic test_backpressure();
      int n;
      hold_left = LONG_HOLD;
      for (n = 0; n < 6; n++) begin
         send_word(logic'($urandom_range(0, 1)), pick_message());
      end
   endtask

   // Sender pauses mid-stream until every owed word has arrived.
   task automatic test_sender_pause();
      int n;
      for (n = 0; n < 20; n++) begin
         send_word(logic'($urandom_range(0, 1)), pick_message());
      end
      drain();
      for (n = 0; n < 20; n++) begin
         send_word(logic'($urandom_range(0, 1)), pick_message());
      end
   endtask

   // Closing stretch at full rate on both sides.
   task automatic test_full_rate();
      int n;
      set_config({$urandom, $urandom}, {$urandom, $urandom});
      idle_on = 1'b0;
      for (n = 0; n < 80; n++) begin
         send_word(logic'($urandom_range(0, 1)), pick_message());
      end
   endtask

   // Receiver: random stall bursts, plus the long hold-off when requested.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (idle_on && stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Result check against the oldest owed word.
   always @(posedge clock) begin
      cipher_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected result word", rsp_result_low, 64'h0);
         end else begin
            want = expected_words.pop_front();
            if (rsp_result_low !== want.low) begin
               report_mismatch("result_low", rsp_result_low, want.low);
            end
            if (rsp_result_high !== want.high) begin
               report_mismatch("result_high", 64'(rsp_result_high), 64'(want.high));
            end
         end
      end
   end

   // Watchdog: ends the run after too long without any handshake.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (psel && penable && pwrite)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_op         = OP_ENCRYPT;
      req_message    = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = ADDR_KEY;
      pwdata         = '0;
      key_cfg        = '0;
      frame_cfg      = '0;
      mismatch_count = 0;
      idle_on        = 1'b1;
      hold_left      = 0;
      idle_cycles    = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_random_settings();
      test_backpressure();
      test_sender_pause();
      test_full_rate();

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule : testbench

`default_nettype wire
